[hw/rtl/frame_history_averager_defines.svh]
// Assertion macros shared by the frame history averager checkers.
// Every macro samples on the rising edge of aclk in the module that uses it.
`ifndef FRAME_HISTORY_AVERAGER_DEFINES_SVH
`define FRAME_HISTORY_AVERAGER_DEFINES_SVH

// Concurrent check that is switched off while aresetn is low.
`define FHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define FHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/fha_pkg.sv]
// Shared constants, types and the reciprocal table for the frame history averager.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package fha_pkg;

    // Field and register widths.
    localparam int FHA_DATA_W        = 24;
    localparam int FHA_FTOA_W        = 4;
    localparam int FHA_FLEN_W        = 11;
    localparam int FHA_CFG_DATA_W    = 11;
    localparam int FHA_RECIP_W       = 32;
    localparam int FHA_RECIP_ARG_W   = 6;

    // Default sizes of the history memory.
    localparam int FHA_MAX_FRAMES    = 8;
    localparam int FHA_MAX_FRAME_LEN = 1024;

    // Register reset values.
    localparam logic [FHA_FTOA_W-1:0] FHA_FTOA_RESET = 4'd4;
    localparam logic [FHA_FLEN_W-1:0] FHA_FLEN_RESET = 11'd1024;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FRAMES_TO_AVERAGE = 1'b0,
        CFG_FRAME_LENGTH      = 1'b1
    } cfg_index_t;

    // Approximate reciprocal floor((2^32 - 1) / c) for divisors 1 to 32.
    // The quotient estimate it gives is low by at most one.
    function automatic logic [FHA_RECIP_W-1:0] fha_recip(input logic [FHA_RECIP_ARG_W-1:0] c);
        logic [FHA_RECIP_W-1:0] r;
        case (c)
            6'd1:    r = 32'd4294967295;
            6'd2:    r = 32'd2147483647;
            6'd3:    r = 32'd1431655765;
            6'd4:    r = 32'd1073741823;
            6'd5:    r = 32'd858993459;
            6'd6:    r = 32'd715827882;
            6'd7:    r = 32'd613566756;
            6'd8:    r = 32'd536870911;
            6'd9:    r = 32'd477218588;
            6'd10:   r = 32'd429496729;
            6'd11:   r = 32'd390451572;
            6'd12:   r = 32'd357913941;
            6'd13:   r = 32'd330382099;
            6'd14:   r = 32'd306783378;
            6'd15:   r = 32'd286331153;
            6'd16:   r = 32'd268435455;
            6'd17:   r = 32'd252645135;
            6'd18:   r = 32'd238609294;
            6'd19:   r = 32'd226050910;
            6'd20:   r = 32'd214748364;
            6'd21:   r = 32'd204522252;
            6'd22:   r = 32'd195225786;
            6'd23:   r = 32'd186737708;
            6'd24:   r = 32'd178956970;
            6'd25:   r = 32'd171798691;
            6'd26:   r = 32'd165191049;
            6'd27:   r = 32'd159072862;
            6'd28:   r = 32'd153391689;
            6'd29:   r = 32'd148102320;
            6'd30:   r = 32'd143165576;
            6'd31:   r = 32'd138547332;
            6'd32:   r = 32'd134217727;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/fha_history_mem.sv]
// History memory of the frame history averager: one write port, one read port.
// Read data is registered. Depends on fha_pkg.
`timescale 1ns / 1ps

module fha_history_mem
    import fha_pkg::*;
#(
    parameter int MAX_FRAMES    = FHA_MAX_FRAMES,
    parameter int MAX_FRAME_LEN = FHA_MAX_FRAME_LEN
) (
    input  logic                                                  aclk,
    input  logic                                                  wr_en,
    input  logic [$clog2(MAX_FRAMES)+$clog2(MAX_FRAME_LEN)-1:0]   wr_addr,
    input  logic signed [FHA_DATA_W-1:0]                          wr_data,
    input  logic                                                  rd_en,
    input  logic [$clog2(MAX_FRAMES)+$clog2(MAX_FRAME_LEN)-1:0]   rd_addr,
    output logic signed [FHA_DATA_W-1:0]                          rd_data
);

    localparam int PW    = $clog2(MAX_FRAME_LEN);
    localparam int DEPTH = MAX_FRAMES * (2 ** PW);

    // Address is {slot, position}; slots stay below MAX_FRAMES.
    logic signed [FHA_DATA_W-1:0] mem [0:DEPTH-1];
    logic signed [FHA_DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/fha_divider.sv]
// Four-stage signed divider by a small count (1 to MAX_FRAMES), truncating toward zero.
// Uses a reciprocal multiply and one correction step. Depends on fha_pkg.
`timescale 1ns / 1ps

module fha_divider
    import fha_pkg::*;
#(
    parameter int MAX_FRAMES = FHA_MAX_FRAMES
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              start,
    input  logic signed [FHA_DATA_W+$clog2(MAX_FRAMES)-1:0]   dividend,
    input  logic [$clog2(MAX_FRAMES+1)-1:0]                   divisor,
    output logic                                              done,
    output logic signed [FHA_DATA_W-1:0]                      quotient
);

    localparam int SUMW = FHA_DATA_W + $clog2(MAX_FRAMES);
    localparam int HW   = $clog2(MAX_FRAMES + 1);
    localparam int PRW  = SUMW + FHA_RECIP_W;
    localparam int QCW  = SUMW + HW;

    // Stage valid flags.
    logic v1_reg, v2_reg, v3_reg, done_reg;

    // Stage 1: magnitude, sign and reciprocal.
    logic [SUMW-1:0]         mag1_reg;
    logic                    neg1_reg;
    logic [FHA_RECIP_W-1:0]  recip1_reg;
    logic [HW-1:0]           div1_reg;

    // Stage 2: magnitude times reciprocal.
    logic [PRW-1:0]          prod2_reg;
    logic [SUMW-1:0]         mag2_reg;
    logic                    neg2_reg;
    logic [HW-1:0]           div2_reg;

    // Stage 3: quotient estimate and its product with the divisor.
    logic [SUMW-1:0]         qe3_reg;
    logic [QCW-1:0]          qc3_reg;
    logic [SUMW-1:0]         mag3_reg;
    logic                    neg3_reg;
    logic [HW-1:0]           div3_reg;

    // Stage 4: corrected, signed result.
    logic signed [FHA_DATA_W-1:0] quot_reg;

    logic [SUMW-1:0]         qe_next;
    logic [QCW-1:0]          rem_next;
    logic [SUMW-1:0]         q_next;
    logic [FHA_DATA_W-1:0]   q24_next;

    // Valid pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Correction logic for the last stage.
    always_comb begin
        qe_next  = prod2_reg[PRW-1:FHA_RECIP_W];
        rem_next = QCW'(mag3_reg) - qc3_reg;
        q_next   = (rem_next >= QCW'(div3_reg)) ? (qe3_reg + SUMW'(1)) : qe3_reg;
        q24_next = q_next[FHA_DATA_W-1:0];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        neg1_reg   <= dividend[SUMW-1];
        mag1_reg   <= dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);
        recip1_reg <= fha_recip(FHA_RECIP_ARG_W'(divisor));
        div1_reg   <= divisor;

        prod2_reg  <= PRW'(mag1_reg) * PRW'(recip1_reg);
        mag2_reg   <= mag1_reg;
        neg2_reg   <= neg1_reg;
        div2_reg   <= div1_reg;

        qe3_reg    <= qe_next;
        qc3_reg    <= QCW'(qe_next) * QCW'(div2_reg);
        mag3_reg   <= mag2_reg;
        neg3_reg   <= neg2_reg;
        div3_reg   <= div2_reg;

        quot_reg   <= neg3_reg ? -q24_next : q24_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[hw/rtl/frame_history_averager.sv]
// Frame history averager: moving average over correlation frames, element by element.
// Input beats on s_* carry one element (s_tdata) and a restart flag (s_tuser); each
// beat gives exactly one result beat on m_* with the averaged element and m_tlast set
// on the frame's final element. Registers are written on the cfg_* channel, which is
// always ready; index 0 is frames_to_average, index 1 is frame_length.
// One element is in work at a time: s_tready is high only while the block is idle.
// With frames_to_average of 1 an element goes from acceptance straight to the output
// load. Otherwise it averages count frames (the held frames plus the current one, at
// most frames_to_average) in these steps: one write to the history memory, one read
// per averaged frame through its single read port, the drain state, the start state,
// the four-stage divider and the output load. A ring slot left beyond a lowered
// frames_to_average is first brought back into range, one subtraction a cycle. A new
// element can be taken once its result is loaded and the block is idle again.
// The output register holds a finished result while m_tready is low; the next element
// is accepted meanwhile and waits in its last step until the register frees up.
// Reset (aresetn low, synchronous) clears the ring position, frame count, element
// position and output valid, and restores the register defaults. The history memory
// is not cleared: each frame's entries are written before they are read.
`timescale 1ns / 1ps

module frame_history_averager
    import fha_pkg::*;
#(
    parameter int MAX_FRAMES    = FHA_MAX_FRAMES,
    parameter int MAX_FRAME_LEN = FHA_MAX_FRAME_LEN
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input element stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [FHA_DATA_W-1:0]     s_tdata,   // [23:0] sample_value
    input  logic                      s_tuser,   // [0] restart
    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [FHA_DATA_W-1:0]     m_tdata,   // [23:0] averaged_value
    output logic                      m_tlast,   // last_in_frame
    // Register write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [0:0]                cfg_index,
    input  logic [FHA_CFG_DATA_W-1:0] cfg_data
);

    localparam int SW   = $clog2(MAX_FRAMES);
    localparam int HW   = $clog2(MAX_FRAMES + 1);
    localparam int PW   = $clog2(MAX_FRAME_LEN);
    localparam int LW   = $clog2(MAX_FRAME_LEN + 1);
    localparam int AW   = SW + PW;
    localparam int SUMW = FHA_DATA_W + $clog2(MAX_FRAMES);
    localparam int KCW  = (HW > FHA_FTOA_W) ? HW : FHA_FTOA_W;
    localparam int LCW  = (LW > FHA_FLEN_W) ? LW : FHA_FLEN_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRAP  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [FHA_FTOA_W-1:0] ftoa_reg;
    logic [FHA_FLEN_W-1:0] flen_reg;

    // Ring bookkeeping.
    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [HW-1:0] frames_held_reg, frames_held_next;
    logic [PW-1:0] elem_pos_reg, elem_pos_next;

    // Per-element working registers.
    logic signed [FHA_DATA_W-1:0] sample_reg, sample_next;
    logic [HW-1:0]  k_reg, k_next;
    logic [SW-1:0]  slot_base_reg, slot_base_next;
    logic [HW-1:0]  held_base_reg, held_base_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           last_reg, last_next;
    logic [HW-1:0]  count_reg, count_next;
    logic [SW-1:0]  rd_idx_reg, rd_idx_next;
    logic           rd_valid_reg, rd_valid_next;
    logic signed [SUMW-1:0]       acc_reg, acc_next;
    logic signed [FHA_DATA_W-1:0] result_reg, result_next;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [FHA_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    // Values derived at acceptance.
    logic [KCW-1:0] ftoa_ext;
    logic [HW-1:0]  k_eff;
    logic [LCW-1:0] flen_ext;
    logic [LW-1:0]  len_eff;
    logic [LW-1:0]  pos_in;
    logic [LW-1:0]  pos_c;
    logic [SW-1:0]  slot_in;
    logic [HW-1:0]  held_in;
    logic [HW-1:0]  held_c;
    logic [HW-1:0]  slot_inc;

    // Memory and divider connections.
    logic                         mem_wr_en;
    logic [AW-1:0]                mem_wr_addr;
    logic                         mem_rd_en;
    logic [AW-1:0]                mem_rd_addr;
    logic signed [FHA_DATA_W-1:0] mem_rd_data;
    logic                         div_start;
    logic                         div_done;
    logic signed [FHA_DATA_W-1:0] div_quot;

    logic s_accept;
    logic out_free;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Effective count and length with out-of-range settings clamped,
    // and the element's bookkeeping after an optional restart.
    always_comb begin
        ftoa_ext = KCW'(ftoa_reg);
        if (ftoa_reg == '0) begin
            k_eff = HW'(1);
        end else if (ftoa_ext > KCW'(MAX_FRAMES)) begin
            k_eff = HW'(MAX_FRAMES);
        end else begin
            k_eff = HW'(ftoa_ext);
        end

        flen_ext = LCW'(flen_reg);
        if (flen_ext < LCW'(2)) begin
            len_eff = LW'(2);
        end else if (flen_ext > LCW'(MAX_FRAME_LEN)) begin
            len_eff = LW'(MAX_FRAME_LEN);
        end else begin
            len_eff = LW'(flen_ext);
        end

        slot_in = s_tuser ? '0 : write_slot_reg;
        held_in = s_tuser ? '0 : frames_held_reg;
        pos_in  = s_tuser ? '0 : LW'(elem_pos_reg);
        pos_c   = (pos_in > len_eff - LW'(1)) ? (len_eff - LW'(1)) : pos_in;
        held_c  = (held_in > k_eff) ? k_eff : held_in;
    end

    // Next ring slot after the current one, before wrapping.
    assign slot_inc = HW'(slot_reg) + HW'(1);

    // Sequencer and datapath next values.
    always_comb begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        frames_held_next = frames_held_reg;
        elem_pos_next    = elem_pos_reg;
        sample_next      = sample_reg;
        k_next           = k_reg;
        slot_base_next   = slot_base_reg;
        held_base_next   = held_base_reg;
        slot_next        = slot_reg;
        pos_next         = pos_reg;
        last_next        = last_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        rd_valid_next    = 1'b0;
        acc_next         = acc_reg;
        result_next      = result_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tlast_next     = m_tlast_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = {slot_reg, pos_reg};
        mem_rd_en        = 1'b0;
        mem_rd_addr      = {rd_idx_reg, pos_reg};
        div_start        = 1'b0;

        // Sum the history entries as their read data returns.
        if (rd_valid_reg) begin
            acc_next = acc_reg + SUMW'(mem_rd_data);
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    sample_next    = $signed(s_tdata);
                    k_next         = k_eff;
                    slot_base_next = slot_in;
                    held_base_next = held_in;
                    slot_next      = slot_in;
                    pos_next       = PW'(pos_c);
                    last_next      = (pos_c + LW'(1) >= len_eff);
                    count_next     = (held_c < k_eff) ? (held_c + HW'(1)) : k_eff;
                    result_next    = $signed(s_tdata);
                    state_next     = (k_eff == HW'(1)) ? S_OUT : S_WRAP;
                end
            end
            S_WRAP: begin
                // Bring the slot into range of the count, one subtraction a cycle,
                // then store the element in its slot.
                if (HW'(slot_reg) >= k_reg) begin
                    slot_next = SW'(HW'(slot_reg) - k_reg);
                end else begin
                    mem_wr_en   = 1'b1;
                    rd_idx_next = '0;
                    acc_next    = '0;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                // One history read per averaged frame.
                mem_rd_en     = 1'b1;
                rd_valid_next = 1'b1;
                rd_idx_next   = rd_idx_reg + SW'(1);
                if (HW'(rd_idx_reg) == count_reg - HW'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_START;
            end
            S_START: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    result_next = div_quot;
                    state_next  = S_OUT;
                end
            end
            S_OUT: begin
                // Load the output register and commit the bookkeeping.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    m_tlast_next  = last_reg;
                    elem_pos_next = last_reg ? '0 : (pos_reg + PW'(1));
                    if ((k_reg != HW'(1)) && last_reg) begin
                        write_slot_next  = (slot_inc == k_reg) ? '0 : SW'(slot_inc);
                        frames_held_next = count_reg;
                    end else begin
                        write_slot_next  = slot_base_reg;
                        frames_held_next = held_base_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            frames_held_reg <= '0;
            elem_pos_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            frames_held_reg <= frames_held_next;
            elem_pos_reg    <= elem_pos_next;
            rd_valid_reg    <= rd_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ftoa_reg <= FHA_FTOA_RESET;
            flen_reg <= FHA_FLEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAMES_TO_AVERAGE: ftoa_reg <= cfg_data[FHA_FTOA_W-1:0];
                CFG_FRAME_LENGTH:      flen_reg <= cfg_data[FHA_FLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        sample_reg    <= sample_next;
        k_reg         <= k_next;
        slot_base_reg <= slot_base_next;
        held_base_reg <= held_base_next;
        slot_reg      <= slot_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        count_reg     <= count_next;
        rd_idx_reg    <= rd_idx_next;
        acc_reg       <= acc_next;
        result_reg    <= result_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // History of the last frames, addressed by {slot, position}.
    fha_history_mem #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_history_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (sample_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sum divided by the frame count.
    fha_divider #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

[hw/rtl/fha_checker.sv]
// Port-level checks for the frame history averager, bound to the top level.
// Depends on fha_pkg and the assertion macros in frame_history_averager_defines.svh.
`timescale 1ns / 1ps
`include "frame_history_averager_defines.svh"

module fha_checker
    import fha_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [FHA_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    // A stalled result beat keeps its contents.
    `FHA_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // Reset empties the output register.
    `FHA_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // Only one element is in work: the input closes right after a beat is taken.
    `FHA_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "input still open after a beat")

    // No result can appear in the cycle right after its element is taken.
    `FHA_ASSERT(a_no_early_result, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result appeared too early")

endmodule

bind frame_history_averager fha_checker u_fha_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
